// File: sv/kpc_pkg.sv
// Package for the key press classifier: payload structs, state struct, key codes,
// display pattern constants and defaults. No dependencies.
package kpc_pkg;

  localparam int STEP_TICKS_DEFAULT = 20;
  localparam logic [3:0] LONG_STEPS_RESET = 4'd3;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  typedef enum logic [1:0] {
    KEY_POWER  = 2'd0,
    KEY_PUMP   = 2'd1,
    KEY_VIB    = 2'd2,
    KEY_HEATER = 2'd3
  } key_t;

  localparam logic [7:0] PAT_UPPER = 8'hf0;
  localparam logic [7:0] PAT_LOWER = 8'h0f;
  localparam logic [7:0] PAT_FULL  = 8'hff;
  localparam logic [7:0] PAT_BLANK = 8'h00;

  typedef struct packed {
    logic       mode;
    logic [1:0] key_id;
    logic       key_held;
  } kpc_in_t;

  typedef struct packed {
    logic       short_press;
    logic       long_flag;
    logic [1:0] pressed_key;
    logic       line_a;
    logic       line_b;
    logic       power_on;
    logic [7:0] grid_one;
    logic [7:0] grid_two;
  } kpc_out_t;

  typedef struct packed {
    logic       armed;
    logic [7:0] tick_count;
    logic [3:0] long_count;
    logic [1:0] latched_key;
    logic       drive_a;
    logic       drive_b;
    logic       power_line;
    logic [7:0] pattern_one;
    logic [7:0] pattern_two;
  } kpc_state_t;

endpackage

// File: sv/key_press_classifier_toggles_top.sv
// Top level of the key press classifier with toggled actuator lines.
// Depends on kpc_pkg and kpc_core.
//
//   channel   direction  handshake                     payload
//   item      in         item_valid / item_ready       kpc_in_t  (mode, key_id, key_held)
//   result    out        result_valid / result_ready   kpc_out_t (pulses, lines, grids)
//   cfg       in         cfg_we (no wait)              cfg_data = long_steps
//
// One transaction in, one transaction out. An accepted item waits in the input
// register, then the classifier logic updates the state and loads the result
// register; one item per cycle sustained while result_ready is high, set by the single
// pass through kpc_core. While a result waits, the input register accepts only if empty.
// Synchronous active-high reset returns state to its reset values (lines A and B
// high, everything else low); long_steps resets to 3.
// With result_ready low both registers fill and item_ready drops.
module key_press_classifier_toggles_top #(
  parameter int STEP_TICKS = kpc_pkg::STEP_TICKS_DEFAULT,
  localparam int PW = $clog2(STEP_TICKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  kpc_pkg::kpc_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output kpc_pkg::kpc_out_t result,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data
);
  import kpc_pkg::*;

  // input register
  logic       in_full;
  kpc_in_t    in_item;
  logic       advance;

  // classifier state
  kpc_state_t state;
  kpc_state_t state_next;
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [3:0] long_steps;
  kpc_out_t   result_next;

  assign advance    = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
    if (item_valid && item_ready) begin
      in_item <= item;
    end
  end

  // config must be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      long_steps <= LONG_STEPS_RESET;
    end else if (cfg_we) begin
      long_steps <= cfg_data;
    end
  end

  kpc_core #(
    .STEP_TICKS(STEP_TICKS)
  ) u_core (
    .item       (in_item),
    .long_steps (long_steps),
    .cur        (state),
    .phase      (phase),
    .nxt        (state_next),
    .phase_next (phase_next),
    .result     (result_next)
  );

  // state and result register move together, once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.armed       <= 1'b0;
      state.tick_count  <= '0;
      state.long_count  <= '0;
      state.latched_key <= '0;
      state.drive_a     <= 1'b1;
      state.drive_b     <= 1'b1;
      state.power_line  <= 1'b0;
      state.pattern_one <= '0;
      state.pattern_two <= '0;
      phase             <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
        phase <= phase_next;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (advance) begin
      result <= result_next;
    end
  end

  // never both classifications from one transaction
  a_one_class: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.short_press && result.long_flag))
    else $error("short and long press in one transaction");

  // a long press always leaves line A cleared
  a_long_clears_a: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.long_flag) |-> !result.line_a)
    else $error("line A set after long press");

  // step phase stays below the step length
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < PW'(STEP_TICKS))
    else $error("step phase out of range");

  // disarmed timer holds no count
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !state.armed |-> (state.tick_count == 8'd0 && state.long_count == 4'd0 && phase == '0))
    else $error("counters nonzero while disarmed");

  // a result is loaded only from a full input register
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> $past(in_full))
    else $error("result without input");

endmodule

// File: sv/kpc_core.sv
// Next-state and result logic for one transaction of the key press classifier.
// Purely combinational. Depends on kpc_pkg.
module kpc_core #(
  parameter int STEP_TICKS = kpc_pkg::STEP_TICKS_DEFAULT,
  localparam int PW = $clog2(STEP_TICKS + 1)
) (
  input  kpc_pkg::kpc_in_t    item,
  input  logic [3:0]          long_steps,
  input  kpc_pkg::kpc_state_t cur,
  input  logic [PW-1:0]       phase,
  output kpc_pkg::kpc_state_t nxt,
  output logic [PW-1:0]       phase_next,
  output kpc_pkg::kpc_out_t   result
);
  import kpc_pkg::*;

  logic [7:0] tick_inc;
  logic       boundary;
  logic       sp;
  logic       lp;

  always_comb begin
    nxt        = cur;
    phase_next = phase;
    sp         = 1'b0;
    lp         = 1'b0;
    boundary   = 1'b0;
    tick_inc   = cur.tick_count + 8'd1;

    if (item.mode == MODE_EDGE) begin
      nxt.armed       = 1'b1;
      nxt.latched_key = item.key_id;
    end else if (cur.armed) begin
      if (item.key_held) begin
        nxt.tick_count = tick_inc;
        // phase tracks tick_count mod STEP_TICKS; wrap of the 8-bit count restarts it
        boundary   = (tick_inc == 8'd0) || (phase == PW'(STEP_TICKS - 1));
        phase_next = boundary ? '0 : phase + PW'(1);
      end else begin
        nxt.tick_count = '0;
        nxt.long_count = '0;
        nxt.armed      = 1'b0;
        boundary       = 1'b1;
        phase_next     = '0;
      end

      if (boundary) begin
        if (item.key_held) begin
          nxt.long_count = cur.long_count + 4'd1;
        end else begin
          sp = 1'b1;
          unique case (key_t'(cur.latched_key))
            KEY_HEATER: begin
              nxt.drive_b     = ~cur.drive_b;
              nxt.pattern_one = nxt.drive_b ? PAT_UPPER : PAT_BLANK;
            end
            KEY_VIB: begin
              nxt.drive_a     = ~cur.drive_a;
              nxt.pattern_one = nxt.drive_a ? PAT_BLANK : PAT_LOWER;
            end
            KEY_PUMP: begin
              nxt.drive_a     = ~cur.drive_a;
              nxt.pattern_two = nxt.drive_a ? PAT_UPPER : PAT_BLANK;
            end
            KEY_POWER: begin
              nxt.drive_b     = ~cur.drive_b;
              nxt.pattern_two = nxt.drive_b ? PAT_BLANK : PAT_LOWER;
            end
            default: ;
          endcase
        end

        if (nxt.long_count > long_steps) begin
          lp              = 1'b1;
          nxt.long_count  = '0;
          nxt.tick_count  = '0;
          nxt.armed       = 1'b0;
          phase_next      = '0;
          nxt.drive_a     = 1'b0;
          nxt.power_line  = ~cur.power_line;
          nxt.pattern_one = nxt.power_line ? PAT_FULL : PAT_BLANK;
          nxt.pattern_two = nxt.pattern_one;
        end
      end
    end

    result.short_press = sp;
    result.long_flag   = lp;
    result.pressed_key = nxt.latched_key;
    result.line_a      = nxt.drive_a;
    result.line_b      = nxt.drive_b;
    result.power_on    = nxt.power_line;
    result.grid_one    = nxt.pattern_one;
    result.grid_two    = nxt.pattern_two;
  end

endmodule
